// ===== src/vpa_pkg.sv =====
`timescale 1ns / 1ps

package vpa_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned LEN_W    = ADDR_W + 1;
  localparam int unsigned ID_W     = 8;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned POLICY_W = 2;
  localparam int unsigned JOB_ID_W = 8;
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned REGION_W = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BSTART_W = 16;
  localparam int unsigned BLEN_W   = 17;

  localparam int unsigned SUM_W    = ((LEN_W > SIZE_W) ? LEN_W : SIZE_W) + 2;

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_ADD     = 2'd2
  } action_e;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RELEASE,
    OP_ADD,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                 op;
    policy_e             pol;
    logic [ID_W-1:0]     id;
    logic [SIZE_W-1:0]   size;
    logic [ADDR_W-1:0]   base;
    logic [LEN_W-1:0]    len;
  } item_t;

  // Clip a length so that the range does not run past the top of the address space
  function automatic logic [LEN_W-1:0] clip_len(input logic [ADDR_W-1:0] start,
                                                input logic [SUM_W-1:0] len);
    logic [SUM_W-1:0] room;
    room = (SUM_W'(1) << ADDR_W) - SUM_W'(start);
    return (len > room) ? LEN_W'(room) : LEN_W'(len);
  endfunction

endpackage

// ===== src/vpa_if.sv =====
`timescale 1ns / 1ps

interface vpa_in_if;
  logic                          valid;
  logic                          ready;
  logic [vpa_pkg::ACTION_W-1:0]  action;
  logic [vpa_pkg::POLICY_W-1:0]  policy;
  logic [vpa_pkg::JOB_ID_W-1:0]  job_id;
  logic [vpa_pkg::SIZE_W-1:0]    request_size;
  logic [vpa_pkg::REGION_W-1:0]  region_start;

  modport source (output valid, action, policy, job_id, request_size, region_start,
                  input ready);
  modport sink (input valid, action, policy, job_id, request_size, region_start,
                output ready);
endinterface

interface vpa_out_if;
  logic                          valid;
  logic                          ready;
  logic [vpa_pkg::STATUS_W-1:0]  status;
  logic [vpa_pkg::BSTART_W-1:0]  block_start;
  logic [vpa_pkg::BLEN_W-1:0]    block_length;

  modport source (output valid, status, block_start, block_length, input ready);
  modport sink (input valid, status, block_start, block_length, output ready);
endinterface

// ===== src/vpa_front.sv =====
`timescale 1ns / 1ps

module vpa_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  vpa_in_if.sink         in_i,
  output logic           q_valid_o,
  input  logic           q_ready_i,
  output vpa_pkg::item_t q_item_o
);

  vpa_pkg::item_t              fifo_q [vpa_pkg::QDEPTH];
  vpa_pkg::item_t              item_in;
  logic [vpa_pkg::QPTR_W-1:0]  wp_q, rp_q;
  logic [vpa_pkg::QCNT_W-1:0]  cnt_q;
  logic                        push, pop;
  logic [vpa_pkg::ADDR_W-1:0]  base;
  logic [vpa_pkg::LEN_W-1:0]   clipped;

  assign base    = vpa_pkg::ADDR_W'(in_i.region_start);
  assign clipped = vpa_pkg::clip_len(base, vpa_pkg::SUM_W'(in_i.request_size));

  // Classify the transaction before it is queued
  always_comb begin
    item_in.id   = vpa_pkg::ID_W'(in_i.job_id);
    item_in.size = in_i.request_size;
    item_in.base = base;
    item_in.len  = clipped;
    case (in_i.policy)
      vpa_pkg::POL_BEST:  item_in.pol = vpa_pkg::POL_BEST;
      vpa_pkg::POL_WORST: item_in.pol = vpa_pkg::POL_WORST;
      default:            item_in.pol = vpa_pkg::POL_FIRST;
    endcase
    case (in_i.action)
      vpa_pkg::ACT_ALLOC:   item_in.op = vpa_pkg::OP_ALLOC;
      vpa_pkg::ACT_RELEASE: item_in.op = vpa_pkg::OP_RELEASE;
      vpa_pkg::ACT_ADD:     item_in.op = (clipped == '0) ? vpa_pkg::OP_NOP : vpa_pkg::OP_ADD;
      default:              item_in.op = vpa_pkg::OP_NOP;
    endcase
  end

  assign in_i.ready = (cnt_q != vpa_pkg::QCNT_W'(vpa_pkg::QDEPTH));
  assign push       = in_i.valid && in_i.ready;
  assign q_valid_o  = (cnt_q != '0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop) begin
        rp_q <= rp_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= vpa_pkg::QCNT_W'(vpa_pkg::QDEPTH))
    else $error("queue count out of range");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == vpa_pkg::QCNT_W'(vpa_pkg::QDEPTH)) |-> !in_i.ready)
    else $error("queue accepts while full");

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_o && !q_ready_i) |=> q_valid_o)
    else $error("queued transaction dropped");

endmodule

// ===== src/vpa_back.sv =====
`timescale 1ns / 1ps

module vpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_ready_o,
  input  vpa_pkg::item_t q_item_i,
  vpa_out_if.source      out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_RESP
  } state_e;

  localparam int unsigned IW = vpa_pkg::IDX_W;
  localparam int unsigned AW = vpa_pkg::ADDR_W;
  localparam int unsigned LW = vpa_pkg::LEN_W;
  localparam int unsigned SW = vpa_pkg::SUM_W;

  // Table storage
  logic [AW-1:0]               fs_mem [vpa_pkg::ENTRIES];
  logic [LW-1:0]               fl_mem [vpa_pkg::ENTRIES];
  logic [vpa_pkg::ID_W-1:0]    ji_mem [vpa_pkg::ENTRIES];
  logic [AW-1:0]               js_mem [vpa_pkg::ENTRIES];
  logic [LW-1:0]               jl_mem [vpa_pkg::ENTRIES];
  logic [vpa_pkg::ENTRIES-1:0] free_valid_q, job_valid_q;

  logic [AW-1:0]               fs_rd_q, js_rd_q;
  logic [LW-1:0]               fl_rd_q, jl_rd_q;
  logic [vpa_pkg::ID_W-1:0]    ji_rd_q;

  state_e                      state_q;
  vpa_pkg::item_t              item_q;
  logic                        phase_free_q;
  logic [IW-1:0]               scan_q, rd_idx_q;
  logic                        ev_q;
  logic [AW-1:0]               ins_base_q;
  logic [LW-1:0]               ins_len_q;

  logic                        jf_fnd_q, je_fnd_q, fe_fnd_q, pk_fnd_q, lo_fnd_q, hi_fnd_q;
  logic [IW-1:0]               jf_idx_q, je_idx_q, fe_idx_q, pk_idx_q, lo_idx_q, hi_idx_q;
  logic [AW-1:0]               jf_start_q, pk_start_q, lo_start_q;
  logic [LW-1:0]               jf_len_q, pk_len_q, lo_len_q, hi_len_q;

  vpa_pkg::status_e            res_status_q, out_status_q;
  logic [AW-1:0]               res_start_q, out_start_q;
  logic [LW-1:0]               res_len_q, out_len_q;
  logic                        out_vld_q;

  // Scan match terms on the registered read data
  logic          fv, jv, fit, better, lo_m, hi_m, jm;
  logic [SW-1:0] fs_x, fl_x;

  // Commit decisions
  vpa_pkg::status_e cm_status;
  logic [AW-1:0]    cm_start;
  logic [LW-1:0]    cm_len;
  logic             fw_en, fv_set, fv_clr, jw_en, jv_clr;
  logic [IW-1:0]    fw_idx, fv_clr_idx, jw_idx, jv_clr_idx;
  logic [AW-1:0]    fw_start;
  logic [LW-1:0]    fw_len;
  logic             commit;

  assign fv   = free_valid_q[rd_idx_q];
  assign jv   = job_valid_q[rd_idx_q];
  assign fs_x = SW'(fs_rd_q);
  assign fl_x = SW'(fl_rd_q);
  assign fit  = fv && (fl_x >= SW'(item_q.size));
  assign lo_m = fv && ((fs_x + fl_x) == SW'(ins_base_q));
  assign hi_m = fv && (fs_x == (SW'(ins_base_q) + SW'(ins_len_q)));
  assign jm   = jv && (ji_rd_q == item_q.id);

  always_comb begin
    if (item_q.pol == vpa_pkg::POL_BEST && fl_rd_q != pk_len_q) begin
      better = fl_rd_q < pk_len_q;
    end else if (item_q.pol == vpa_pkg::POL_WORST && fl_rd_q != pk_len_q) begin
      better = fl_rd_q > pk_len_q;
    end else begin
      better = fs_rd_q < pk_start_q;
    end
  end

  assign commit = (state_q == S_COMMIT) && phase_free_q;

  always_comb begin
    cm_status  = vpa_pkg::ST_OK;
    cm_start   = '0;
    cm_len     = '0;
    fw_en      = 1'b0;
    fw_idx     = '0;
    fw_start   = '0;
    fw_len     = '0;
    fv_set     = 1'b0;
    fv_clr     = 1'b0;
    fv_clr_idx = '0;
    jw_en      = 1'b0;
    jw_idx     = je_idx_q;
    jv_clr     = 1'b0;
    jv_clr_idx = jf_idx_q;
    if (item_q.op == vpa_pkg::OP_ALLOC) begin
      if (!je_fnd_q) begin
        cm_status = vpa_pkg::ST_FULL;
      end else if (item_q.size == '0 || !pk_fnd_q) begin
        cm_status = vpa_pkg::ST_NO_FIT;
      end else begin
        cm_start = pk_start_q;
        cm_len   = LW'(item_q.size);
        jw_en    = commit;
        if (SW'(pk_len_q) == SW'(item_q.size)) begin
          fv_clr     = commit;
          fv_clr_idx = pk_idx_q;
        end else begin
          fw_en    = commit;
          fw_idx   = pk_idx_q;
          fw_start = pk_start_q + AW'(item_q.size);
          fw_len   = pk_len_q - LW'(item_q.size);
        end
      end
    end else begin
      if (lo_fnd_q) begin
        fw_en    = commit;
        fw_idx   = lo_idx_q;
        fw_start = lo_start_q;
        fw_len   = vpa_pkg::clip_len(lo_start_q, SW'(lo_len_q) + SW'(ins_len_q)
                                     + (hi_fnd_q ? SW'(hi_len_q) : SW'(0)));
        if (hi_fnd_q) begin
          fv_clr     = commit;
          fv_clr_idx = hi_idx_q;
        end
      end else if (hi_fnd_q) begin
        fw_en    = commit;
        fw_idx   = hi_idx_q;
        fw_start = ins_base_q;
        fw_len   = vpa_pkg::clip_len(ins_base_q, SW'(hi_len_q) + SW'(ins_len_q));
      end else if (fe_fnd_q) begin
        fw_en    = commit;
        fv_set   = commit;
        fw_idx   = fe_idx_q;
        fw_start = ins_base_q;
        fw_len   = ins_len_q;
      end else begin
        cm_status = vpa_pkg::ST_FULL;
      end
      if (cm_status == vpa_pkg::ST_OK) begin
        cm_start = ins_base_q;
        cm_len   = ins_len_q;
        jv_clr   = commit && (item_q.op == vpa_pkg::OP_RELEASE);
      end
    end
  end

  // Memories: one write and one registered read per table per cycle
  always_ff @(posedge clk_i) begin
    if (fw_en) begin
      fs_mem[fw_idx] <= fw_start;
      fl_mem[fw_idx] <= fw_len;
    end
    if (jw_en) begin
      ji_mem[jw_idx] <= item_q.id;
      js_mem[jw_idx] <= pk_start_q;
      jl_mem[jw_idx] <= LW'(item_q.size);
    end
    fs_rd_q <= fs_mem[scan_q];
    fl_rd_q <= fl_mem[scan_q];
    ji_rd_q <= ji_mem[scan_q];
    js_rd_q <= js_mem[scan_q];
    jl_rd_q <= jl_mem[scan_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_valid_q <= '0;
      job_valid_q  <= '0;
    end else begin
      if (fv_set) begin
        free_valid_q[fw_idx] <= 1'b1;
      end
      if (fv_clr) begin
        free_valid_q[fv_clr_idx] <= 1'b0;
      end
      if (jw_en) begin
        job_valid_q[jw_idx] <= 1'b1;
      end
      if (jv_clr) begin
        job_valid_q[jv_clr_idx] <= 1'b0;
      end
    end
  end

  assign q_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      item_q       <= '0;
      phase_free_q <= 1'b0;
      scan_q       <= '0;
      rd_idx_q     <= '0;
      ev_q         <= 1'b0;
      ins_base_q   <= '0;
      ins_len_q    <= '0;
      jf_fnd_q     <= 1'b0;
      je_fnd_q     <= 1'b0;
      fe_fnd_q     <= 1'b0;
      pk_fnd_q     <= 1'b0;
      lo_fnd_q     <= 1'b0;
      hi_fnd_q     <= 1'b0;
      jf_idx_q     <= '0;
      je_idx_q     <= '0;
      fe_idx_q     <= '0;
      pk_idx_q     <= '0;
      lo_idx_q     <= '0;
      hi_idx_q     <= '0;
      jf_start_q   <= '0;
      pk_start_q   <= '0;
      lo_start_q   <= '0;
      jf_len_q     <= '0;
      pk_len_q     <= '0;
      lo_len_q     <= '0;
      hi_len_q     <= '0;
      res_status_q <= vpa_pkg::ST_OK;
      res_start_q  <= '0;
      res_len_q    <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= vpa_pkg::ST_OK;
      out_start_q  <= '0;
      out_len_q    <= '0;
    end else begin
      // The response state reloads the output register itself
      if (out_vld_q && out_o.ready && state_q != S_RESP) begin
        out_vld_q <= 1'b0;
      end

      // Fold the entry read last cycle into the running search
      if (ev_q) begin
        if (!phase_free_q) begin
          if (jm && !jf_fnd_q) begin
            jf_fnd_q   <= 1'b1;
            jf_idx_q   <= rd_idx_q;
            jf_start_q <= js_rd_q;
            jf_len_q   <= jl_rd_q;
          end
        end else begin
          if (!fv && !fe_fnd_q) begin
            fe_fnd_q <= 1'b1;
            fe_idx_q <= rd_idx_q;
          end
          if (!jv && !je_fnd_q) begin
            je_fnd_q <= 1'b1;
            je_idx_q <= rd_idx_q;
          end
          if (fit && (!pk_fnd_q || better)) begin
            pk_fnd_q   <= 1'b1;
            pk_idx_q   <= rd_idx_q;
            pk_start_q <= fs_rd_q;
            pk_len_q   <= fl_rd_q;
          end
          if (lo_m && !lo_fnd_q) begin
            lo_fnd_q   <= 1'b1;
            lo_idx_q   <= rd_idx_q;
            lo_start_q <= fs_rd_q;
            lo_len_q   <= fl_rd_q;
          end
          if (hi_m && !hi_fnd_q) begin
            hi_fnd_q <= 1'b1;
            hi_idx_q <= rd_idx_q;
            hi_len_q <= fl_rd_q;
          end
        end
      end

      case (state_q)
        S_IDLE: begin
          ev_q <= 1'b0;
          if (q_valid_i) begin
            item_q       <= q_item_i;
            ins_base_q   <= q_item_i.base;
            ins_len_q    <= q_item_i.len;
            phase_free_q <= (q_item_i.op != vpa_pkg::OP_RELEASE);
            scan_q       <= '0;
            jf_fnd_q     <= 1'b0;
            je_fnd_q     <= 1'b0;
            fe_fnd_q     <= 1'b0;
            pk_fnd_q     <= 1'b0;
            lo_fnd_q     <= 1'b0;
            hi_fnd_q     <= 1'b0;
            if (q_item_i.op == vpa_pkg::OP_NOP) begin
              res_status_q <= vpa_pkg::ST_OK;
              res_start_q  <= '0;
              res_len_q    <= '0;
              state_q      <= S_RESP;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_idx_q <= scan_q;
          ev_q     <= 1'b1;
          if (scan_q == IW'(vpa_pkg::ENTRIES - 1)) begin
            state_q <= S_DRAIN;
          end else begin
            scan_q <= scan_q + 1'b1;
          end
        end
        S_DRAIN: begin
          ev_q    <= 1'b0;
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!phase_free_q) begin
            if (!jf_fnd_q) begin
              res_status_q <= vpa_pkg::ST_NOT_FOUND;
              res_start_q  <= '0;
              res_len_q    <= '0;
              state_q      <= S_RESP;
            end else begin
              // Job found: walk the free table to place its range
              ins_base_q   <= jf_start_q;
              ins_len_q    <= jf_len_q;
              phase_free_q <= 1'b1;
              scan_q       <= '0;
              state_q      <= S_SCAN;
            end
          end else begin
            res_status_q <= cm_status;
            res_start_q  <= cm_start;
            res_len_q    <= cm_len;
            state_q      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_vld_q || out_o.ready) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_start_q  <= res_start_q;
            out_len_q    <= res_len_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_status_q;
  assign out_o.block_start  = vpa_pkg::BSTART_W'(out_start_q);
  assign out_o.block_length = vpa_pkg::BLEN_W'(out_len_q);

  a_commit_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_COMMIT |-> $past(state_q) == S_DRAIN)
    else $error("commit entered without a completed scan");

  a_scan_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && $past(state_q) == S_SCAN) |-> scan_q == IW'($past(scan_q) + 1'b1))
    else $error("scan index skipped");

  a_pop_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_valid_i && q_ready_o) |=> state_q != S_IDLE)
    else $error("popped transaction not started");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q != vpa_pkg::ST_OK) |-> (out_start_q == '0 && out_len_q == '0))
    else $error("failed transaction carries a range");

endmodule

// ===== src/variable_partition_allocator_top.sv =====
`timescale 1ns / 1ps

// Variable partition allocator: keeps a free-range table and a job table of
// 64 entries each and answers each transaction with one result. The front
// classifies transactions into a two-deep queue; the back walks the tables
// one entry per cycle through registered memory reads. Add and allocate
// make one full table walk followed by decision and commit; release makes
// a job-table walk followed by a free-table walk (a release whose job is not
// found stops after the first walk); an unknown action or an empty add
// skips the walk. Both tables are empty after reset with no clearing pass.
module variable_partition_allocator_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  vpa_in_if.sink     in_i,
  vpa_out_if.source  out_o
);

  logic           q_valid, q_ready;
  vpa_pkg::item_t q_item;

  vpa_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  vpa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .out_o     (out_o)
  );

endmodule

// ===== dv/vpa_tb_if.sv =====
`timescale 1ns / 1ps

// Channel interfaces come from the RTL (src/vpa_if.sv); this file holds the
// scoreboard class shared by the testbench top.
package vpa_tb_pkg;
  import vpa_pkg::*;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] start;
    logic [16:0] length;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [15:0] fr_start [ENTRIES];
    logic [16:0] fr_len   [ENTRIES];
    bit          fr_vld   [ENTRIES];
    logic [7:0]  jb_id    [ENTRIES];
    logic [15:0] jb_start [ENTRIES];
    logic [16:0] jb_len   [ENTRIES];
    bit          jb_vld   [ENTRIES];
    alloc_result_t pending[$];
    int errors;

    function new();
      errors = 0;
      foreach (fr_vld[i]) begin
        fr_vld[i] = 0;
        jb_vld[i] = 0;
      end
    endfunction

    function int first_empty(bit vld[ENTRIES]);
      foreach (vld[i])
        if (!vld[i]) return i;
      return ENTRIES;
    endfunction

    function logic [16:0] trim(logic [31:0] s, logic [31:0] l);
      logic [31:0] room;
      room = 32'h10000 - s;
      return (l > room) ? room[16:0] : l[16:0];
    endfunction

    function logic [1:0] merge_in(logic [31:0] base, logic [31:0] len);
      int lo, hi, slot;
      lo = ENTRIES;
      hi = ENTRIES;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!fr_vld[i]) continue;
        if (lo == ENTRIES && 32'(fr_start[i]) + 32'(fr_len[i]) == base) lo = i;
        if (hi == ENTRIES && 32'(fr_start[i]) == base + len) hi = i;
      end
      if (lo != ENTRIES && hi != ENTRIES) begin
        fr_len[lo] = trim(fr_start[lo], 32'(fr_len[lo]) + len + 32'(fr_len[hi]));
        fr_vld[hi] = 0;
      end else if (lo != ENTRIES) begin
        fr_len[lo] = trim(fr_start[lo], 32'(fr_len[lo]) + len);
      end else if (hi != ENTRIES) begin
        fr_start[hi] = base[15:0];
        fr_len[hi] = trim(base, 32'(fr_len[hi]) + len);
      end else begin
        slot = first_empty(fr_vld);
        if (slot == ENTRIES) return ST_FULL;
        fr_start[slot] = base[15:0];
        fr_len[slot] = len[16:0];
        fr_vld[slot] = 1;
      end
      return ST_OK;
    endfunction

    function bit prefer(logic [1:0] pol, int a, int b);
      if (pol == POL_BEST && fr_len[a] != fr_len[b]) return fr_len[a] < fr_len[b];
      if (pol == POL_WORST && fr_len[a] != fr_len[b]) return fr_len[a] > fr_len[b];
      return fr_start[a] < fr_start[b];
    endfunction

    function void note_request(logic [1:0] act, logic [1:0] pol, logic [7:0] id,
                               logic [16:0] size, logic [15:0] base);
      alloc_result_t r;
      int slot, pick;
      logic [16:0] len;
      r.status = ST_OK;
      r.start = 0;
      r.length = 0;
      if (act == ACT_ALLOC) begin
        slot = first_empty(jb_vld);
        if (slot == ENTRIES) r.status = ST_FULL;
        else if (size == 0) r.status = ST_NO_FIT;
        else begin
          pick = ENTRIES;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!fr_vld[i] || fr_len[i] < size) continue;
            if (pick == ENTRIES || prefer(pol, i, pick)) pick = i;
          end
          if (pick == ENTRIES) r.status = ST_NO_FIT;
          else begin
            r.start = fr_start[pick];
            r.length = size;
            jb_id[slot] = id;
            jb_start[slot] = fr_start[pick];
            jb_len[slot] = size;
            jb_vld[slot] = 1;
            if (fr_len[pick] == size) fr_vld[pick] = 0;
            else begin
              fr_start[pick] += size[15:0];
              fr_len[pick] -= size;
            end
          end
        end
      end else if (act == ACT_RELEASE) begin
        pick = ENTRIES;
        for (int i = 0; i < ENTRIES; i++)
          if (jb_vld[i] && jb_id[i] == id) begin
            pick = i;
            break;
          end
        if (pick == ENTRIES) r.status = ST_NOT_FOUND;
        else begin
          r.status = merge_in(jb_start[pick], jb_len[pick]);
          if (r.status == ST_OK) begin
            r.start = jb_start[pick];
            r.length = jb_len[pick];
            jb_vld[pick] = 0;
          end
        end
      end else if (act == ACT_ADD) begin
        len = trim(base, size);
        if (len != 0) begin
          r.status = merge_in(base, len);
          if (r.status == ST_OK) begin
            r.start = base;
            r.length = len;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [1:0] st, logic [15:0] bs, logic [16:0] bl);
      alloc_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result status=%0d start=%0d length=%0d",
                 $time, st, bs, bl);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (st !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, st);
        errors++;
      end
      if (bs !== e.start) begin
        $display("%0t: block_start expected %0d actual %0d", $time, e.start, bs);
        errors++;
      end
      if (bl !== e.length) begin
        $display("%0t: block_length expected %0d actual %0d", $time, e.length, bl);
        errors++;
      end
    endfunction
  endclass
endpackage

// ===== dv/variable_partition_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module variable_partition_allocator_top_tb;
  import vpa_pkg::*;
  import vpa_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   accepted;

  vpa_in_if  req_ch ();
  vpa_out_if rsp_ch ();

  variable_partition_allocator_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch.sink),
    .out_o  (rsp_ch.source)
  );

  alloc_scoreboard board = new();

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Sample results at the rising edge
  always @(posedge clk_i)
    if (rst_ni && rsp_ch.valid && rsp_ch.ready)
      board.check_result(rsp_ch.status, rsp_ch.block_start, rsp_ch.block_length);

  // Randomly stall the result side unless calm is set
  initial begin
    rsp_ch.ready = 0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
    end
  end

  // Valid stays high after a send; drain, or a random stall in the next send, lowers it
  task automatic send(logic [1:0] act, logic [1:0] pol, logic [7:0] id,
                      logic [16:0] size, logic [15:0] base);
    while (!calm && $urandom_range(99) < 38) begin
      req_ch.valid <= 0;
      @(negedge clk_i);
    end
    req_ch.valid <= 1;
    req_ch.action <= act;
    req_ch.policy <= pol;
    req_ch.job_id <= id;
    req_ch.request_size <= size;
    req_ch.region_start <= base;
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(act, pol, id, size, base);
    accepted++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    req_ch.valid <= 0;
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic random_item();
    int k;
    logic [16:0] sz;
    k = $urandom_range(99);
    sz = ($urandom_range(9) == 0) ? 17'($urandom_range(65536)) : 17'($urandom_range(2048));
    if (k < 45)
      send(ACT_ALLOC, 2'($urandom_range(3)), 8'($urandom_range(40)), sz, 16'($urandom));
    else if (k < 80)
      send(ACT_RELEASE, 2'($urandom), 8'($urandom_range(45)), sz, 16'($urandom));
    else if (k < 97)
      send(ACT_ADD, 2'($urandom), 8'($urandom), sz, 16'($urandom));
    else
      send(2'd3, 2'($urandom), 8'($urandom), 17'($urandom), 16'($urandom));
  endtask

  initial begin
    calm = 0;
    accepted = 0;
    rst_ni = 0;
    req_ch.valid = 0;
    req_ch.action = ACT_ALLOC;
    req_ch.policy = POL_FIRST;
    req_ch.job_id = 0;
    req_ch.request_size = 0;
    req_ch.region_start = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // Directed: empty tables, extremes, policies, merges, clipping
    send(ACT_ALLOC, POL_FIRST, 8'd1, 17'd10, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd1, 17'd0, 16'd0);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd0, 16'd5);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd100, 16'd1000);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd300, 16'd2000);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd50, 16'd3000);
    send(ACT_ALLOC, POL_BEST, 8'd2, 17'd40, 16'd0);
    send(ACT_ALLOC, POL_WORST, 8'd3, 17'd40, 16'd0);
    send(ACT_ALLOC, 2'd3, 8'd255, 17'd100, 16'd0);
    send(ACT_ALLOC, POL_FIRST, 8'd4, 17'd0, 16'd0);
    send(ACT_ALLOC, POL_FIRST, 8'd4, 17'h1FFFF, 16'd0);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'h1FFFF, 16'hFFF0);
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd65536, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd255, 17'd0, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd2, 17'd0, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd3, 17'd0, 16'd0);
    send(2'd3, 2'd3, 8'hAA, 17'h15555, 16'h5555);
    send(ACT_ALLOC, POL_FIRST, 8'd9, 17'd65536, 16'd0);
    send(ACT_ALLOC, POL_FIRST, 8'd9, 17'd1, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd9, 17'd0, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd9, 17'd0, 16'd0);

    // Hold off until every result is back
    drain();

    // Fill the job table, then one more, then free a duplicate id
    for (int i = 0; i < 65; i++) send(ACT_ALLOC, POL_FIRST, 8'd7, 17'd1, 16'd0);
    send(ACT_RELEASE, POL_FIRST, 8'd7, 17'd0, 16'd0);
    // Fragment the free table: add single-unit ranges at every other address so they do not merge with each other
    send(ACT_ADD, POL_FIRST, 8'd0, 17'd65536, 16'd0);
    for (int i = 0; i < 70; i++)
      send(ACT_ADD, POL_FIRST, 8'd0, 17'd1, 16'(200 + 2 * i));

    calm = 1;
    for (int i = 0; i < 60; i++) random_item();
    calm = 0;
    while (accepted < 520) random_item();

    drain();
    repeat (300) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== sim.f =====
src/vpa_pkg.sv
src/vpa_if.sv
src/vpa_front.sv
src/vpa_back.sv
src/variable_partition_allocator_top.sv
dv/vpa_tb_if.sv
dv/variable_partition_allocator_top_tb.sv
